FILE: rtl/dotq_pkg.sv
// shared types, constants and codes for the deadline ordered timer queue
// no dependencies
package dotq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int ID_BITS     = 8;

  localparam int ADDR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RAM_DEPTH   = 2 ** ADDR_BITS;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_BITS  = TIME_BITS + ID_BITS;
  localparam int DATA_BITS   = ((ENTRY_BITS + 7) / 8) * 8;

  localparam int CMD_BITS    = 2;
  localparam int KIND_BITS   = 2;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam logic [CMD_BITS-1:0] CMD_INSERT_ABS = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_INSERT_REL = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_TICK       = 2'd2;

  localparam logic [KIND_BITS-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_REFUSED  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_FIRED    = 2'd2;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [ID_BITS-1:0]   callback;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_READ,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_INS_DONE,
    ST_INS_FULL,
    ST_TICK_HEAD,
    ST_TICK_NEXT,
    ST_TICK_LOOK
  } dotq_state_t;

  typedef enum logic {
    RD_BASE,
    RD_PREV
  } rd_sel_t;

  typedef struct packed {
    logic                 accept;
    logic                 calc_insert;
    logic                 tick_time;
    logic                 rd_en;
    rd_sel_t              rd_sel;
    logic                 wr_en;
    logic                 wr_new;
    logic                 j_load;
    logic                 j_dec;
    logic                 count_inc;
    logic                 pend_load;
    logic                 pop;
    logic                 out_load;
    logic [KIND_BITS-1:0] out_kind;
    logic                 out_last;
  } dotq_ctl_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] command;
    logic                full;
    logic                empty;
    logic                j_one;
    logic                greater;
    logic                due;
    logic                same;
    logic                slot_free;
  } dotq_stat_t;

endpackage

FILE: rtl/dotq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module dotq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/dotq_ctrl.sv
// controller state machine of the timer queue
// depends on dotq_pkg
module dotq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  dotq_pkg::dotq_stat_t stat,
  output dotq_pkg::dotq_ctl_t  ctl
);
  import dotq_pkg::*;

  dotq_state_t state;
  dotq_state_t state_next;
  logic        more;

  assign more = !stat.empty && stat.same;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (stat.command == CMD_INSERT_ABS || stat.command == CMD_INSERT_REL) begin
          priority if (stat.full) state_next = ST_INS_FULL;
          else if (stat.empty)    state_next = ST_INS_PUT;
          else                    state_next = ST_INS_READ;
        end else if (stat.command == CMD_TICK) begin
          state_next = stat.empty ? ST_IDLE : ST_TICK_HEAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_INS_READ: state_next = ST_INS_CMP;
      ST_INS_CMP: begin
        priority if (!stat.greater) state_next = ST_INS_DONE;
        else if (stat.j_one)        state_next = ST_INS_PUT;
        else                        state_next = ST_INS_READ;
      end
      ST_INS_PUT: state_next = ST_INS_DONE;
      ST_INS_DONE, ST_INS_FULL: begin
        if (stat.slot_free) state_next = ST_IDLE;
      end
      ST_TICK_HEAD: state_next = stat.due ? ST_TICK_NEXT : ST_IDLE;
      ST_TICK_NEXT: state_next = ST_TICK_LOOK;
      ST_TICK_LOOK: begin
        if (stat.slot_free) state_next = more ? ST_TICK_NEXT : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.rd_sel   = RD_BASE;
    ctl.out_kind = KIND_ACCEPTED;
    s_tready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        ctl.accept = s_tvalid;
      end
      ST_DECODE: begin
        priority if (stat.command == CMD_INSERT_ABS || stat.command == CMD_INSERT_REL) begin
          ctl.calc_insert = 1'b1;
          ctl.j_load      = 1'b1;
        end else if (stat.command == CMD_TICK) begin
          ctl.tick_time = 1'b1;
          ctl.rd_en     = !stat.empty;
        end else begin
          ctl.accept = 1'b0;
        end
      end
      ST_INS_READ: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_PREV;
      end
      ST_INS_CMP: begin
        ctl.wr_en = 1'b1;
        if (stat.greater) begin
          ctl.j_dec = 1'b1;
        end else begin
          ctl.wr_new    = 1'b1;
          ctl.count_inc = 1'b1;
        end
      end
      ST_INS_PUT: begin
        ctl.wr_en     = 1'b1;
        ctl.wr_new    = 1'b1;
        ctl.count_inc = 1'b1;
      end
      ST_INS_DONE: begin
        ctl.out_load = stat.slot_free;
        ctl.out_kind = KIND_ACCEPTED;
        ctl.out_last = 1'b1;
      end
      ST_INS_FULL: begin
        ctl.out_load = stat.slot_free;
        ctl.out_kind = KIND_REFUSED;
        ctl.out_last = 1'b1;
      end
      ST_TICK_HEAD: begin
        ctl.pend_load = stat.due;
        ctl.pop       = stat.due;
      end
      ST_TICK_NEXT: begin
        ctl.rd_en = !stat.empty;
      end
      ST_TICK_LOOK: begin
        ctl.out_load  = stat.slot_free;
        ctl.out_kind  = KIND_FIRED;
        ctl.out_last  = !more;
        ctl.pend_load = stat.slot_free && more;
        ctl.pop       = stat.slot_free && more;
      end
      default: begin
        ctl.accept = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/dotq_dp.sv
// datapath of the timer queue: input latch, time counter, circular entry table,
// sorted insert shifting, fired group tracking and the output word register
// depends on dotq_pkg and dotq_ram
module dotq_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [dotq_pkg::DATA_BITS-1:0]     s_tdata,
  input  logic [dotq_pkg::CMD_BITS-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dotq_pkg::DATA_BITS-1:0]     m_tdata,
  output logic [dotq_pkg::KIND_BITS-1:0]     m_tuser,
  output logic                               m_tlast,
  input  dotq_pkg::dotq_ctl_t                ctl,
  output dotq_pkg::dotq_stat_t               stat
);
  import dotq_pkg::*;

  logic [CMD_BITS-1:0]   in_command;
  logic [TIME_BITS-1:0]  in_time;
  logic [ID_BITS-1:0]    in_id;
  logic [TIME_BITS-1:0]  new_dl;
  logic [TIME_BITS-1:0]  current_time;
  logic [COUNT_BITS-1:0] count;
  logic [ADDR_BITS-1:0]  base;
  logic [ADDR_BITS-1:0]  j;
  entry_t                pend;
  logic [TIME_BITS-1:0]  head;
  logic [TIME_BITS:0]    sum;
  logic [TIME_BITS-1:0]  sum_sat;

  logic                  rd_en;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [ADDR_BITS-1:0]  wr_addr;
  entry_t                wr_data;
  entry_t                rd_data;

  logic [ID_BITS-1:0]    out_id;
  logic [TIME_BITS-1:0]  out_dl;

  // input word latch
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      in_command <= s_tuser;
      in_time    <= s_tdata[TIME_BITS-1:0];
      in_id      <= s_tdata[ENTRY_BITS-1:TIME_BITS];
    end
  end

  // deadline of an insert, delay saturates
  assign sum     = {1'b0, current_time} + {1'b0, in_time};
  assign sum_sat = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ctl.calc_insert) begin
      new_dl <= (in_command == CMD_INSERT_ABS) ? in_time : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
    end else if (ctl.tick_time && current_time != TIME_MAX) begin
      current_time <= current_time + TIME_BITS'(1);
    end
  end

  // occupancy and head pointer of the circular table
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      base  <= '0;
    end else if (ctl.count_inc) begin
      count <= count + COUNT_BITS'(1);
    end else if (ctl.pop) begin
      count <= count - COUNT_BITS'(1);
      base  <= base + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.j_load) begin
      j <= count[ADDR_BITS-1:0];
    end else if (ctl.j_dec) begin
      j <= j - ADDR_BITS'(1);
    end
  end

  assign rd_en   = ctl.rd_en;
  assign rd_addr = (ctl.rd_sel == RD_BASE) ? base : base + j - ADDR_BITS'(1);
  assign wr_addr = base + j;
  assign wr_data = ctl.wr_new ? entry_t'{deadline: new_dl, callback: in_id} : rd_data;

  dotq_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // entry waiting to fire and the deadline of its group
  always_ff @(posedge clk) begin
    if (ctl.pend_load) begin
      pend <= rd_data;
      head <= rd_data.deadline;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      m_tuser <= ctl.out_kind;
      m_tlast <= ctl.out_last;
      if (ctl.out_kind == KIND_FIRED) begin
        out_id <= pend.callback;
        out_dl <= head;
      end else begin
        out_id <= in_id;
        out_dl <= new_dl;
      end
    end
  end

  assign m_tdata = DATA_BITS'({out_dl, out_id});

  assign stat.command   = in_command;
  assign stat.full      = (count == COUNT_BITS'(QUEUE_DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.j_one     = (j == ADDR_BITS'(1));
  assign stat.greater   = (rd_data.deadline > new_dl);
  assign stat.due       = (rd_data.deadline <= current_time);
  assign stat.same      = (rd_data.deadline == head);
  assign stat.slot_free = !m_tvalid || m_tready;

endmodule

FILE: rtl/deadline_ordered_timer_queue.sv
// top level of the deadline ordered timer queue
// depends on dotq_pkg, dotq_ctrl, dotq_dp
//
// The slave channel takes one command word at a time: s_tuser selects insert at
// an absolute deadline, insert after a delay, or tick; s_tdata carries the time
// value and the callback id. The master channel returns result words: m_tuser
// gives the kind (insert accepted, insert refused, alarm fired), m_tdata the id
// and the deadline, m_tlast marks the final word caused by a command.
// A refused insert passes the decode and full states. An accepted insert on an
// empty table writes the new entry directly; otherwise a sorted shift walks down
// from the tail, reading each stored entry and moving it up one slot while it is
// later than the new deadline, then writes the new entry into the freed slot. A
// tick on an empty table only advances the time; otherwise it reads the head and,
// if it is due, emits one word for each entry of the group of equal earliest deadlines.
// A new command is taken only after the previous one has finished.
// The result sits in an output register, so the block goes back to idle while
// the last word waits; a stalled receiver holds the emitting sequence until
// the register frees. Reset empties the table and sets the time to zero at once.
module deadline_ordered_timer_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dotq_pkg::DATA_BITS-1:0] s_tdata,   // time_value, callback_id
  input  logic [dotq_pkg::CMD_BITS-1:0]  s_tuser,   // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dotq_pkg::DATA_BITS-1:0] m_tdata,   // callback_id, deadline
  output logic [dotq_pkg::KIND_BITS-1:0] m_tuser,   // kind
  output logic                           m_tlast
);
  import dotq_pkg::*;

  dotq_ctl_t  ctl;
  dotq_stat_t stat;

  dotq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  dotq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .ctl      (ctl),
    .stat     (stat)
  );

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (rst)
    ctl.count_inc |-> !stat.full)
    else $error("entry added to a full table");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !stat.empty)
    else $error("entry removed from an empty table");

  a_no_word_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> stat.slot_free)
    else $error("output word overwritten before taken");

  a_busy_while_emitting: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !s_tready)
    else $error("command taken while a result is produced");

endmodule
